>>> hdl/olt_pkg.sv
// olt_pkg: shared types and codes for the ordered list table
// no dependencies; used by the interfaces, controller, datapath and top level
package olt_pkg;

  localparam int unsigned KindW   = 2;
  localparam int unsigned ValueW  = 32;
  localparam int unsigned StatusW = 2;
  localparam int unsigned PosW    = 4;
  localparam int unsigned CountW  = 5;

  typedef enum logic [KindW-1:0] {
    KIND_INSERT = 2'd0,
    KIND_SEARCH = 2'd1,
    KIND_REMOVE = 2'd2,
    KIND_NOP    = 2'd3
  } olt_kind_e;

  typedef enum logic [StatusW-1:0] {
    ST_OK        = 2'd0,
    ST_NOT_FOUND = 2'd1,
    ST_FULL      = 2'd2
  } olt_status_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_SHIFT,
    S_REPLY
  } olt_state_e;

  // controller to datapath
  typedef struct packed {
    logic        load;
    logic        ins;
    logic        step;
    logic        shift_wr;
    logic        dec;
    logic        set_res;
    logic        pos_from_idx;
    olt_status_e res_code;
    logic        out_load;
  } olt_cmd_t;

  // datapath to controller
  typedef struct packed {
    olt_kind_e new_kind;
    olt_kind_e cur_kind;
    logic      full;
    logic      at_end;
    logic      hit;
  } olt_stat_t;

endpackage

>>> hdl/olt_in_if.sv
// olt_in_if: request channel of the ordered list table (valid/ready)
// widths from olt_pkg
interface olt_in_if
  import olt_pkg::*;
;
  logic                     valid;
  logic                     ready;
  logic [KindW-1:0]         kind;
  logic signed [ValueW-1:0] value;

  modport source (output valid, output kind, output value, input ready);
  modport sink (input valid, input kind, input value, output ready);
endinterface

>>> hdl/olt_out_if.sv
// olt_out_if: response channel of the ordered list table (valid/ready)
// widths from olt_pkg
interface olt_out_if
  import olt_pkg::*;
;
  logic               valid;
  logic               ready;
  logic [StatusW-1:0] status;
  logic [PosW-1:0]    position;
  logic [CountW-1:0]  entry_count;
  logic               is_empty;

  modport source (output valid, output status, output position, output entry_count,
                  output is_empty, input ready);
  modport sink (input valid, input status, input position, input entry_count,
                input is_empty, output ready);
endinterface

>>> hdl/olt_ctrl.sv
// olt_ctrl: sequencing state machine for insert, search and remove
// depends on olt_pkg; drives olt_dp through olt_cmd_t and reads olt_stat_t
module olt_ctrl
  import olt_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  input  olt_stat_t stat_i,
  output olt_cmd_t  cmd_o
);

  olt_state_e state_q, state_d;
  logic       out_valid_q, out_valid_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_comb begin
    state_d     = state_q;
    out_valid_d = out_valid_q & ~out_ready_i;
    in_ready_o  = 1'b0;
    cmd_o       = '0;
    cmd_o.res_code = ST_OK;

    unique case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          unique case (stat_i.new_kind)
            KIND_INSERT: begin
              cmd_o.set_res = 1'b1;
              if (stat_i.full) begin
                cmd_o.res_code = ST_FULL;
              end else begin
                cmd_o.ins = 1'b1;
              end
              state_d = S_REPLY;
            end
            KIND_SEARCH, KIND_REMOVE: begin
              state_d = S_SCAN;
            end
            default: begin
              cmd_o.set_res = 1'b1;
              state_d       = S_REPLY;
            end
          endcase
        end
      end
      S_SCAN: begin
        priority if (stat_i.at_end) begin
          cmd_o.set_res  = 1'b1;
          cmd_o.res_code = ST_NOT_FOUND;
          state_d        = S_REPLY;
        end else if (stat_i.hit) begin
          cmd_o.set_res = 1'b1;
          if (stat_i.cur_kind == KIND_REMOVE) begin
            cmd_o.step = 1'b1;
            state_d    = S_SHIFT;
          end else begin
            cmd_o.pos_from_idx = 1'b1;
            state_d            = S_REPLY;
          end
        end else begin
          cmd_o.step = 1'b1;
        end
      end
      S_SHIFT: begin
        if (stat_i.at_end) begin
          cmd_o.dec = 1'b1;
          state_d   = S_REPLY;
        end else begin
          cmd_o.shift_wr = 1'b1;
          cmd_o.step     = 1'b1;
        end
      end
      S_REPLY: begin
        if (!out_valid_q || out_ready_i) begin
          cmd_o.out_load = 1'b1;
          out_valid_d    = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  assign out_valid_o = out_valid_q;

endmodule

>>> hdl/olt_dp.sv
// olt_dp: entry memory, count, scan index, key compare and response registers
// depends on olt_pkg; controlled by olt_ctrl
module olt_dp
  import olt_pkg::*;
#(
  parameter int unsigned CAPACITY = 16
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  olt_cmd_t                 cmd_i,
  output olt_stat_t                stat_o,
  input  logic [KindW-1:0]         in_kind_i,
  input  logic signed [ValueW-1:0] in_value_i,
  output logic [StatusW-1:0]       out_status_o,
  output logic [PosW-1:0]          out_position_o,
  output logic [CountW-1:0]        out_entry_count_o,
  output logic                     out_is_empty_o
);

  localparam int unsigned AW = $clog2(CAPACITY);
  localparam int unsigned CW = $clog2(CAPACITY + 1);

  logic [ValueW-1:0] mem [CAPACITY];

  logic [CW-1:0]     count_q, count_d;
  logic [CW-1:0]     idx_q, idx_d;
  olt_kind_e         kind_q;
  logic [ValueW-1:0] key_q;
  logic [ValueW-1:0] rdata_q;
  olt_status_e       st_q;
  logic [PosW-1:0]   pos_q;
  logic [AW-1:0]     raddr;
  logic              we;
  logic [AW-1:0]     waddr;
  logic [ValueW-1:0] wdata;

  logic [StatusW-1:0] out_status_q;
  logic [PosW-1:0]    out_position_q;
  logic [CountW-1:0]  out_count_q;
  logic               out_empty_q;

  always_comb begin
    idx_d = idx_q;
    if (cmd_i.load) begin
      idx_d = '0;
    end else if (cmd_i.step) begin
      idx_d = idx_q + CW'(1);
    end
  end

  always_comb begin
    count_d = count_q;
    if (cmd_i.ins) begin
      count_d = count_q + CW'(1);
    end else if (cmd_i.dec) begin
      count_d = count_q - CW'(1);
    end
  end

  // read address follows the next index so rdata_q holds entry idx_q while idx_q is below CAPACITY
  assign raddr = (idx_d < CW'(CAPACITY)) ? idx_d[AW-1:0] : '0;

  always_comb begin
    we    = 1'b0;
    waddr = count_q[AW-1:0];
    wdata = in_value_i;
    if (cmd_i.ins) begin
      we = 1'b1;
    end else if (cmd_i.shift_wr) begin
      we    = 1'b1;
      waddr = AW'(idx_q - CW'(1));
      wdata = rdata_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_q <= mem[raddr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      idx_q   <= '0;
    end else begin
      count_q <= count_d;
      idx_q   <= idx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      kind_q <= olt_kind_e'(in_kind_i);
      key_q  <= in_value_i;
    end
    if (cmd_i.set_res) begin
      st_q  <= cmd_i.res_code;
      pos_q <= cmd_i.pos_from_idx ? PosW'(idx_q) : '0;
    end
    if (cmd_i.out_load) begin
      out_status_q   <= st_q;
      out_position_q <= pos_q;
      out_count_q    <= CountW'(count_q);
      out_empty_q    <= (count_q == '0);
    end
  end

  assign stat_o.new_kind = olt_kind_e'(in_kind_i);
  assign stat_o.cur_kind = kind_q;
  assign stat_o.full     = (count_q >= CW'(CAPACITY));
  assign stat_o.at_end   = (idx_q >= count_q);
  assign stat_o.hit      = (rdata_q == key_q);

  assign out_status_o      = out_status_q;
  assign out_position_o    = out_position_q;
  assign out_entry_count_o = out_count_q;
  assign out_is_empty_o    = out_empty_q;

endmodule

>>> hdl/ordered_list_table.sv
// ordered_list_table: insertion-ordered list of signed values, top level
// depends on olt_pkg, olt_in_if, olt_out_if, olt_ctrl and olt_dp
//
//   port   dir  carries
//   in_i   in   kind, value
//   out_o  out  status, position, entry_count, is_empty
//
// insert and unused kinds go from accept straight to the reply state
// search and remove scan the entry memory, read one entry a cycle, and a remove
// then shifts the entries after the hit down one entry a cycle
// one transaction is in work at a time; the response register lets the next
// request be accepted while a response is still waiting
// reset clears the count; entries need no clearing
module ordered_list_table
  import olt_pkg::*;
#(
  parameter int unsigned CAPACITY = 16
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  olt_in_if.sink    in_i,
  olt_out_if.source out_o
);

  olt_cmd_t  cmd;
  olt_stat_t stat;

  olt_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_ready_o  (in_i.ready),
    .out_valid_o (out_o.valid),
    .out_ready_i (out_o.ready),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  olt_dp #(
    .CAPACITY (CAPACITY)
  ) u_dp (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cmd_i             (cmd),
    .stat_o            (stat),
    .in_kind_i         (in_i.kind),
    .in_value_i        (in_i.value),
    .out_status_o      (out_o.status),
    .out_position_o    (out_o.position),
    .out_entry_count_o (out_o.entry_count),
    .out_is_empty_o    (out_o.is_empty)
  );

endmodule

>>> tb/sv/ordered_list_table_test.sv
// ordered_list_table_test: self-checking bench for the ordered list table
// depends on olt_pkg, olt_in_if, olt_out_if and ordered_list_table; predicts each
// response from its own copy of the list and checks it as it leaves the block
module ordered_list_table_test;
  timeunit 1ns;
  timeprecision 1ps;
  import olt_pkg::*;

  localparam int Capacity   = 16;
  localparam int RandomOps  = 1000;
  localparam int IdleLimit  = 3000;
  localparam int TailCycles = 40;
  localparam int PoolSize   = 6;

  typedef struct {
    olt_kind_e         kind;
    logic [ValueW-1:0] value;
    bit                wait_drain;
  } list_op_t;

  typedef struct {
    olt_status_e       status;
    logic [PosW-1:0]   position;
    logic [CountW-1:0] entry_count;
    logic              is_empty;
  } list_reply_t;

  logic clk = 1'b0;
  logic rst_ni = 1'b0;

  olt_in_if  in_ch ();
  olt_out_if out_ch ();

  ordered_list_table #(.CAPACITY(Capacity)) uut (
    .clk_i (clk),
    .rst_ni(rst_ni),
    .in_i  (in_ch),
    .out_o (out_ch)
  );

  always #5 clk = ~clk;

  list_op_t          pending_ops[$];
  list_reply_t       expected_replies[$];
  logic [ValueW-1:0] list_entries[Capacity];
  int                list_count = 0;
  int                ops_total = 0;
  int                ops_sent = 0;
  int                ops_accepted = 0;
  int                idle_cycles = 0;
  int                mismatch_count = 0;
  int                kind_seen[4] = '{default: 0};
  int                status_seen[3] = '{default: 0};
  logic [ValueW-1:0] key_pool[PoolSize];

  function automatic list_reply_t list_apply(olt_kind_e kind, logic [ValueW-1:0] value);
    list_reply_t r;
    int hit;
    r.status   = ST_OK;
    r.position = '0;
    hit = -1;
    for (int i = 0; i < list_count; i++) begin
      if (hit < 0 && list_entries[i] == value) hit = i;
    end
    case (kind)
      KIND_INSERT: begin
        if (list_count >= Capacity) begin
          r.status = ST_FULL;
        end else begin
          list_entries[list_count] = value;
          list_count++;
        end
      end
      KIND_SEARCH: begin
        if (hit < 0) r.status = ST_NOT_FOUND;
        else r.position = PosW'(hit);
      end
      KIND_REMOVE: begin
        if (hit < 0) begin
          r.status = ST_NOT_FOUND;
        end else begin
          for (int i = hit; i < list_count - 1; i++) list_entries[i] = list_entries[i + 1];
          list_count--;
        end
      end
      default: ;
    endcase
    r.entry_count = CountW'(list_count);
    r.is_empty    = (list_count == 0);
    return r;
  endfunction

  function automatic void add_op(olt_kind_e kind, logic [ValueW-1:0] value, bit wait_drain);
    list_op_t op;
    op.kind       = kind;
    op.value      = value;
    op.wait_drain = wait_drain;
    pending_ops.push_back(op);
  endfunction

  function automatic int sender_idle_pct();
    int phase;
    phase = (ops_total == 0) ? 0 : ops_accepted * 3 / ops_total;
    return (phase == 0) ? 32 : (phase == 1) ? 69 : 0;
  endfunction

  function automatic int receiver_idle_pct();
    int phase;
    phase = (ops_total == 0) ? 0 : ops_accepted * 3 / ops_total;
    return (phase == 0) ? 69 : (phase == 1) ? 32 : 0;
  endfunction

  // driver: request side and response ready
  always @(negedge clk) begin
    if (rst_ni) begin
      if (!in_ch.valid || ops_accepted == ops_sent) begin
        if (pending_ops.size() > 0
            && !(pending_ops[0].wait_drain && expected_replies.size() > 0)
            && $urandom_range(0, 99) >= sender_idle_pct()) begin
          in_ch.valid <= 1'b1;
          in_ch.kind  <= pending_ops[0].kind;
          in_ch.value <= pending_ops[0].value;
          void'(pending_ops.pop_front());
          ops_sent++;
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
      out_ch.ready <= ($urandom_range(0, 99) >= receiver_idle_pct());
    end
  end

  // monitor: response check, prediction and watchdog
  always @(posedge clk) begin
    list_reply_t want;
    bit any_taken;
    any_taken = 1'b0;
    if (rst_ni) begin
      if (out_ch.valid && out_ch.ready) begin
        any_taken = 1'b1;
        if (expected_replies.size() == 0) begin
          $error("response transaction with no request outstanding");
          mismatch_count++;
        end else begin
          want = expected_replies.pop_front();
          status_seen[int'(want.status)]++;
          if (out_ch.status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, out_ch.status);
            mismatch_count++;
          end
          if (out_ch.position !== want.position) begin
            $error("position: expected %0d, got %0d", want.position, out_ch.position);
            mismatch_count++;
          end
          if (out_ch.entry_count !== want.entry_count) begin
            $error("entry_count: expected %0d, got %0d", want.entry_count,
                   out_ch.entry_count);
            mismatch_count++;
          end
          if (out_ch.is_empty !== want.is_empty) begin
            $error("is_empty: expected %0d, got %0d", want.is_empty, out_ch.is_empty);
            mismatch_count++;
          end
        end
      end
      if (in_ch.valid && in_ch.ready) begin
        any_taken = 1'b1;
        kind_seen[int'(in_ch.kind)]++;
        expected_replies.push_back(list_apply(olt_kind_e'(in_ch.kind), in_ch.value));
        ops_accepted++;
      end
      if (any_taken) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= IdleLimit) begin
        $display("watchdog: no transaction for %0d cycles", IdleLimit);
        $display("ordered_list_table_test failed");
        $finish;
      end
    end
  end

  initial begin
    int directed_ops;
    int seg_len;
    int pick;
    bit fill_bias;
    logic [ValueW-1:0] key;
    olt_kind_e kind;

    in_ch.valid  = 1'b0;
    in_ch.kind   = KIND_INSERT;
    in_ch.value  = '0;
    out_ch.ready = 1'b0;

    // empty list, unused kind, extremes, duplicates, head removal, full list
    add_op(KIND_SEARCH, 32'd5, 1'b0);
    add_op(KIND_REMOVE, 32'd5, 1'b0);
    add_op(KIND_NOP, 32'hdead_beef, 1'b0);
    add_op(KIND_INSERT, 32'h8000_0000, 1'b0);
    add_op(KIND_INSERT, 32'h7fff_ffff, 1'b0);
    add_op(KIND_INSERT, 32'hffff_ffff, 1'b0);
    add_op(KIND_INSERT, 32'd7, 1'b0);
    add_op(KIND_INSERT, 32'd7, 1'b0);
    add_op(KIND_SEARCH, 32'd7, 1'b0);
    add_op(KIND_REMOVE, 32'h8000_0000, 1'b0);
    add_op(KIND_SEARCH, 32'd7, 1'b0);
    add_op(KIND_SEARCH, 32'h1234_5678, 1'b0);
    for (int i = 0; i < 13; i++) add_op(KIND_INSERT, $urandom, 1'b0);
    directed_ops = pending_ops.size();

    key_pool[0] = 32'h8000_0000;
    key_pool[1] = 32'h7fff_ffff;
    for (int i = 2; i < PoolSize; i++) key_pool[i] = $urandom;

    // segments lean toward filling or toward draining the list
    while (pending_ops.size() < directed_ops + RandomOps) begin
      fill_bias = $urandom_range(0, 1);
      seg_len = $urandom_range(20, 60);
      key_pool[$urandom_range(2, PoolSize - 1)] = $urandom;
      for (int i = 0; i < seg_len; i++) begin
        pick = $urandom_range(0, 99);
        if (pick < 5) kind = KIND_NOP;
        else if (fill_bias) kind = (pick < 60) ? KIND_INSERT : (pick < 80) ? KIND_SEARCH
                                                                         : KIND_REMOVE;
        else kind = (pick < 25) ? KIND_INSERT : (pick < 55) ? KIND_SEARCH : KIND_REMOVE;
        key = ($urandom_range(0, 99) < 85) ? key_pool[$urandom_range(0, PoolSize - 1)]
                                           : $urandom;
        add_op(kind, key, ((pending_ops.size() - directed_ops) % 250) == 0);
      end
    end
    ops_total = pending_ops.size();

    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_ni <= 1'b1;

    while (ops_accepted < ops_total || expected_replies.size() > 0) @(posedge clk);
    repeat (TailCycles) @(posedge clk);

    $display("ran %0d transactions: %0d insert, %0d search, %0d remove, %0d unused kind",
             ops_accepted, kind_seen[KIND_INSERT], kind_seen[KIND_SEARCH],
             kind_seen[KIND_REMOVE], kind_seen[KIND_NOP]);
    $display("responses: %0d ok, %0d not found, %0d dropped on full list",
             status_seen[ST_OK], status_seen[ST_NOT_FOUND], status_seen[ST_FULL]);
    if (mismatch_count == 0) begin
      $display("ordered_list_table_test passed");
    end else begin
      $display("ordered_list_table_test failed");
    end
    $finish;
  end

endmodule
